// ===== rtl/lspg_pkg.sv =====
// shared types, constants and color functions of the led strip pattern generator
package lspg_pkg;

    localparam int DEF_PIXEL_LIMIT = 64;
    localparam int PIX_W           = 6;
    localparam int COLOR_W         = 8;
    localparam int CNT_W           = 7;
    localparam int SHIFT_W         = 3;
    localparam int FRAME_W         = 32;
    localparam int REM_W           = 11;
    localparam int DIV_CNT_W       = 4;
    localparam int DIV_STEPS       = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;
    localparam int OUT_DATA_W      = 32;

    localparam logic [1:0] MODE_CALM = 2'd0;
    localparam logic [1:0] MODE_TEST = 2'd1;
    localparam logic [1:0] MODE_STAR = 2'd2;
    localparam logic [1:0] MODE_SCAN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SHIFT   = 2'd2;

    localparam logic [SHIFT_W-1:0] RST_DIM_SHIFT = 3'd2;
    localparam logic [REM_W-1:0]   CALM_PERIOD   = 11'd1280;
    localparam logic [COLOR_W-1:0] TEST_LEVEL    = 8'd32;
    localparam logic [COLOR_W-1:0] FULL_LEVEL    = 8'd255;
    localparam logic [COLOR_W-1:0] TAIL1_LEVEL   = 8'd20;
    localparam logic [COLOR_W-1:0] TAIL2_LEVEL   = 8'd1;
    localparam logic [COLOR_W-1:0] WHEEL_SEG1    = 8'd85;
    localparam logic [COLOR_W-1:0] WHEEL_SEG2    = 8'd170;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_finish;
        logic emit;
    } lspg_cmd_t;

    typedef struct packed {
        logic div_last;
        logic pix_last;
        logic out_free;
    } lspg_status_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } lspg_rgb_t;

    function automatic logic [COLOR_W-1:0] times3(input logic [COLOR_W-1:0] v);
        times3 = COLOR_W'({v, 1'b0}) + v;
    endfunction

    function automatic lspg_rgb_t wheel_colour(input logic [COLOR_W-1:0] pos);
        lspg_rgb_t c;
        logic [COLOR_W-1:0] t;
        c = '0;
        if (pos < WHEEL_SEG1)
        begin
            t       = times3(pos);
            c.red   = t;
            c.green = FULL_LEVEL - t;
        end
        else if (pos < WHEEL_SEG2)
        begin
            t      = times3(pos - WHEEL_SEG1);
            c.red  = FULL_LEVEL - t;
            c.blue = t;
        end
        else
        begin
            t       = times3(pos - WHEEL_SEG2);
            c.green = t;
            c.blue  = FULL_LEVEL - t;
        end
        wheel_colour = c;
    endfunction

    // base-4 digit sum, since 4 is 1 mod 3
    function automatic logic [1:0] mod3_6(input logic [PIX_W-1:0] k);
        logic [3:0] s;
        logic [2:0] s2;
        s  = 4'(k[1:0]) + 4'(k[3:2]) + 4'(k[5:4]);
        s2 = 3'(s[3:2]) + 3'(s[1:0]);
        mod3_6 = (s2 >= 3'd3) ? 2'(s2 - 3'd3) : s2[1:0];
    endfunction

    // hue step per pixel, 256 / n kept mod 256
    function automatic logic [COLOR_W-1:0] calm_step(input logic [CNT_W-1:0] n);
        logic [COLOR_W-1:0] s;
        case (n)
            7'd1:  s = 8'd0;
            7'd2:  s = 8'd128;
            7'd3:  s = 8'd85;
            7'd4:  s = 8'd64;
            7'd5:  s = 8'd51;
            7'd6:  s = 8'd42;
            7'd7:  s = 8'd36;
            7'd8:  s = 8'd32;
            7'd9:  s = 8'd28;
            7'd10: s = 8'd25;
            7'd11: s = 8'd23;
            7'd12: s = 8'd21;
            7'd13: s = 8'd19;
            7'd14: s = 8'd18;
            7'd15: s = 8'd17;
            7'd16: s = 8'd16;
            7'd17: s = 8'd15;
            7'd18: s = 8'd14;
            7'd19: s = 8'd13;
            7'd20, 7'd21: s = 8'd12;
            7'd22, 7'd23: s = 8'd11;
            7'd24, 7'd25: s = 8'd10;
            7'd26, 7'd27, 7'd28: s = 8'd9;
            7'd29, 7'd30, 7'd31, 7'd32: s = 8'd8;
            7'd33, 7'd34, 7'd35, 7'd36: s = 8'd7;
            7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42: s = 8'd6;
            7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51: s = 8'd5;
            default: s = 8'd4;
        endcase
        calm_step = s;
    endfunction

endpackage

// ===== rtl/lspg_ctrl.sv =====
// frame sequencer of the led strip pattern generator
module lspg_ctrl
    import lspg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  lspg_status_t status,
    output lspg_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_axis_tready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.div_finish = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.pix_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lspg_datapath.sv =====
// config registers, frame counter, remainder unit and pixel pipeline
module lspg_datapath
    import lspg_pkg::*;
#(
    parameter int PIXEL_LIMIT = DEF_PIXEL_LIMIT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [FRAME_W-1:0]    frame_bump,
    input  lspg_cmd_t             cmd,
    output lspg_status_t          status,
    input  logic                  m_axis_tready,
    output logic                  m_axis_tvalid,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(PIXEL_LIMIT);

    logic [1:0]            mode_reg;
    logic [CNT_W-1:0]      pixel_count_reg;
    logic [SHIFT_W-1:0]    dim_shift_reg;
    logic [FRAME_W-1:0]    frame_counter_reg;
    logic [FRAME_W-1:0]    frame_next;
    logic [FRAME_W-1:0]    dividend_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [PIX_W-1:0]      pix_reg;
    logic [PIX_W-1:0]      k_reg;
    logic [PIX_W-1:0]      eye_reg;
    logic                  mirror_reg;
    logic [COLOR_W-1:0]    hue_reg;
    logic [COLOR_W-1:0]    step_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    logic [CNT_W-1:0]      n_eff;
    logic [CNT_W-1:0]      n_m1;
    logic [REM_W-1:0]      div_d;
    logic [REM_W:0]        r1a;
    logic [REM_W:0]        r1;
    logic [REM_W:0]        r2a;
    logic [REM_W:0]        r2;
    logic [CNT_W-1:0]      m_val;
    logic                  m_ge;
    logic [CNT_W-1:0]      m_red;
    logic [CNT_W-1:0]      q_val;
    logic [CNT_W-1:0]      eye_ext;
    logic [CNT_W-1:0]      eye_dist;
    logic [CNT_W-1:0]      pix_ext;
    logic [1:0]            phase;
    logic                  white;
    lspg_rgb_t             colour;
    logic [COLOR_W-1:0]    green_dim;
    logic [COLOR_W-1:0]    red_dim;
    logic [COLOR_W-1:0]    blue_dim;
    logic                  pix_last;

    // effective strip length
    always_comb
    begin
        if (pixel_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (pixel_count_reg > MAX_CNT)
        begin
            n_eff = MAX_CNT;
        end
        else
        begin
            n_eff = pixel_count_reg;
        end
    end

    assign n_m1       = n_eff - CNT_W'(1);
    assign frame_next = frame_counter_reg + FRAME_W'(1) + frame_bump;

    // remainder unit, two dividend bits per step
    assign div_d = (mode_reg == MODE_CALM) ? CALM_PERIOD : REM_W'({n_eff, 1'b0});
    assign r1a   = {rem_reg, dividend_reg[FRAME_W-1]};
    assign r1    = (r1a >= {1'b0, div_d}) ? (r1a - {1'b0, div_d}) : r1a;
    assign r2a   = {r1[REM_W-1:0], dividend_reg[FRAME_W-2]};
    assign r2    = (r2a >= {1'b0, div_d}) ? (r2a - {1'b0, div_d}) : r2a;

    // counter mod 2n folded to mod n
    assign m_val = rem_reg[CNT_W-1:0];
    assign m_ge  = (m_val >= n_eff);
    assign m_red = m_ge ? (m_val - n_eff) : m_val;

    // pixel color
    assign pix_ext  = {1'b0, pix_reg};
    assign eye_ext  = {1'b0, eye_reg};
    assign q_val    = mirror_reg ? (n_m1 - pix_ext) : pix_ext;
    assign eye_dist = (q_val >= eye_ext) ? (q_val - eye_ext) : (eye_ext - q_val);
    assign phase    = mod3_6(k_reg);
    assign white    = frame_counter_reg[0] ? (phase == 2'd2) : (phase == 2'd0);
    assign pix_last = (pix_ext == n_m1);

    always_comb
    begin
        colour = '0;
        case (mode_reg)
            MODE_CALM:
            begin
                colour = wheel_colour(hue_reg);
            end
            MODE_TEST:
            begin
                if (white)
                begin
                    colour.red   = TEST_LEVEL;
                    colour.green = TEST_LEVEL;
                    colour.blue  = TEST_LEVEL;
                end
            end
            MODE_STAR:
            begin
                if (pix_reg == eye_reg)
                begin
                    colour.red   = FULL_LEVEL;
                    colour.green = FULL_LEVEL;
                    colour.blue  = FULL_LEVEL;
                end
            end
            MODE_SCAN:
            begin
                if (eye_dist == CNT_W'(0))
                begin
                    colour.red = FULL_LEVEL;
                end
                else if (eye_dist == CNT_W'(1))
                begin
                    colour.red = TAIL1_LEVEL;
                end
                else if (eye_dist == CNT_W'(2))
                begin
                    colour.red = TAIL2_LEVEL;
                end
            end
            default:
            begin
                colour = '0;
            end
        endcase
    end

    assign green_dim = colour.green >> dim_shift_reg;
    assign red_dim   = colour.red >> dim_shift_reg;
    assign blue_dim  = colour.blue >> dim_shift_reg;

    // config and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_CALM;
            pixel_count_reg   <= MAX_CNT;
            dim_shift_reg     <= RST_DIM_SHIFT;
            frame_counter_reg <= '0;
            div_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_MODE:        mode_reg        <= cfg_data[1:0];
                    REG_PIXEL_COUNT: pixel_count_reg <= cfg_data[CNT_W-1:0];
                    REG_DIM_SHIFT:   dim_shift_reg   <= cfg_data[SHIFT_W-1:0];
                    default:         mode_reg        <= mode_reg;
                endcase
            end
            if (cmd.load)
            begin
                frame_counter_reg <= frame_next;
                div_cnt_reg       <= DIV_CNT_W'(DIV_STEPS - 1);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dividend_reg <= frame_next;
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[FRAME_W-3:0], 2'b00};
            rem_reg      <= r2[REM_W-1:0];
        end
        if (cmd.div_finish)
        begin
            pix_reg    <= '0;
            eye_reg    <= m_red[PIX_W-1:0];
            mirror_reg <= m_ge;
            k_reg      <= (m_red == '0) ? '0 : PIX_W'(n_eff - m_red);
            hue_reg    <= rem_reg[COLOR_W-1:0];
            step_reg   <= calm_step(n_eff);
        end
        else if (cmd.emit)
        begin
            pix_reg <= pix_reg + PIX_W'(1);
            hue_reg <= hue_reg + step_reg;
            k_reg   <= ({1'b0, k_reg} == n_m1) ? '0 : (k_reg + PIX_W'(1));
        end
        if (cmd.emit)
        begin
            out_data_reg <= {2'b00, blue_dim, red_dim, green_dim, pix_reg};
            out_last_reg <= pix_last;
        end
    end

    assign status.div_last = (div_cnt_reg == '0);
    assign status.pix_last = pix_last;
    assign status.out_free = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/led_strip_pattern_generator_top.sv =====
// a taken frame request passes ST_DIV, then ST_FINISH, then ST_EMIT, the pixel output state,
// which registers one pixel per cycle onto m_axis while m_axis_tready allows (n pixels)
// the 16-step remainder unit (two counter bits a step) sets the per-frame overhead
// a new request is taken only once the previous frame's pixels are all issued
// reset is asynchronous active low: counter 0, mode calm, PIXEL_LIMIT (64) pixels, dim shift 2
module led_strip_pattern_generator_top
    import lspg_pkg::*;
#(
    parameter int PIXEL_LIMIT = DEF_PIXEL_LIMIT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [FRAME_W-1:0]    s_axis_tdata,   // frame bump
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // pixel_index, green, red, blue, pad
    output logic                  m_axis_tlast    // last_pixel
);

    lspg_cmd_t    cmd;
    lspg_status_t status;

    assign cfg_ready = 1'b1;

    lspg_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    lspg_datapath #(
        .PIXEL_LIMIT (PIXEL_LIMIT)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .frame_bump    (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
